### hdl/pfde_pkg.sv
`timescale 1ns / 1ps

package pfde_pkg;

	// input item, packed into s_tdata from bit 0 up
	localparam int COLUMN_LSB  = 0;
	localparam int ROW_LSB     = 8;
	localparam int COLOR_LSB   = 16;
	localparam int BWIDTH_LSB  = 18;
	localparam int BHEIGHT_LSB = 26;
	localparam int PIXELS_LSB  = 34;
	localparam int ADDRESS_LSB = 42;
	localparam int S_TDATA_W   = 56;
	localparam int S_TUSER_W   = 3;

	// result item: read_data in [7:0], blit_busy in [8]
	localparam int M_TDATA_W   = 16;
	localparam int BUSY_BIT    = 8;

	localparam logic [2:0] MODE_PLOT   = 3'd0;
	localparam logic [2:0] MODE_BSTART = 3'd1;
	localparam logic [2:0] MODE_BBYTE  = 3'd2;
	localparam logic [2:0] MODE_CLEAR  = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	localparam logic [1:0] COLOR_CLEAR = 2'd0;
	localparam logic [1:0] COLOR_SET   = 2'd1;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_PLOT  = 3'd1,
		OP_BLIT  = 3'd2,
		OP_READ  = 3'd3,
		OP_CLEAR = 3'd4
	} op_t;

	typedef struct packed {
		logic accept;
		logic rd_a;
		logic wr_a;
		logic rd_b;
		logic wr_b;
		logic clr_step;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  in_op;
		logic need_b;
		logic clr_last;
	} dp_stat_t;

endpackage

### hdl/pfde_ctrl.sv
`timescale 1ns / 1ps

module pfde_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	input  pfde_pkg::dp_stat_t    stat,
	output pfde_pkg::ctrl_cmd_t   cmd
);
	import pfde_pkg::*;

	typedef enum logic [7:0] {
		ST_INIT  = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_RD_A  = 8'b0000_0100,
		ST_WR_A  = 8'b0000_1000,
		ST_RD_B  = 8'b0001_0000,
		ST_WR_B  = 8'b0010_0000,
		ST_CLEAR = 8'b0100_0000,
		ST_RESP  = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   take;

	assign s_tready = (state_q == ST_IDLE);
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_INIT: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (take) begin
					cmd.accept = 1'b1;
					case (stat.in_op)
						OP_PLOT, OP_BLIT, OP_READ: state_d = ST_RD_A;
						OP_CLEAR:                  state_d = ST_CLEAR;
						default:                   state_d = ST_RESP;
					endcase
				end
			end
			ST_RD_A: begin
				cmd.rd_a = 1'b1;
				state_d  = ST_WR_A;
			end
			ST_WR_A: begin
				cmd.wr_a = 1'b1;
				state_d  = stat.need_b ? ST_RD_B : ST_RESP;
			end
			ST_RD_B: begin
				cmd.rd_b = 1'b1;
				state_d  = ST_WR_B;
			end
			ST_WR_B: begin
				cmd.wr_b = 1'b1;
				state_d  = ST_RESP;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.clr_last) state_d = ST_RESP;
			end
			ST_RESP: begin
				// wait for a free output slot
				if (!out_valid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !cmd.load_out)
		else $error("result overwritten while held");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !s_tready)
		else $error("second transaction taken while one is in flight");

	a_load_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !s_tready && !cmd.clr_step)
		else $error("result loaded outside of the response step");
`endif

endmodule

### hdl/pfde_dpath.sv
`timescale 1ns / 1ps

module pfde_dpath #(
	parameter int STORE_BYTES  = 1024,
	parameter int PAGE_COLUMNS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [pfde_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [pfde_pkg::S_TUSER_W-1:0]   s_tuser,
	input  pfde_pkg::ctrl_cmd_t              cmd,
	output pfde_pkg::dp_stat_t               stat,
	output logic [pfde_pkg::M_TDATA_W-1:0]   m_tdata
);
	import pfde_pkg::*;

	localparam int MAW     = $clog2(STORE_BYTES);
	localparam int LIN_MAX = 63 * PAGE_COLUMNS + 511 + STORE_BYTES;
	localparam int LIN_W   = $clog2(LIN_MAX + 1);

	// unpacked input fields
	logic [2:0] mode;
	logic [7:0] column, row, bwidth, bheight, pixels;
	logic [1:0] color;
	logic [9:0] address;

	assign mode    = s_tuser;
	assign column  = s_tdata[COLUMN_LSB +: 8];
	assign row     = s_tdata[ROW_LSB +: 8];
	assign color   = s_tdata[COLOR_LSB +: 2];
	assign bwidth  = s_tdata[BWIDTH_LSB +: 8];
	assign bheight = s_tdata[BHEIGHT_LSB +: 8];
	assign pixels  = s_tdata[PIXELS_LSB +: 8];
	assign address = s_tdata[ADDRESS_LSB +: 10];

	// blit state
	logic [7:0] ocol_q, orow_q, cols_q, col_q;
	logic [4:0] pages_q, page_q;
	logic       inv_q, blit_active_q;

	// latched command
	op_t              op_q;
	logic [LIN_W-1:0] addr_q;
	logic [2:0]       shift_q;
	logic [7:0]       data_q;
	logic [1:0]       color_q;
	logic [7:0]       rd_q;
	logic [M_TDATA_W-1:0] out_q;
	logic [MAW-1:0]   clr_q;

	// store
	logic [7:0]       mem [STORE_BYTES];
	logic [7:0]       mem_rdata_q;
	logic             mem_we, mem_re;
	logic [MAW-1:0]   mem_idx;
	logic [7:0]       mem_wdata;

	op_t              in_op;
	logic [LIN_W-1:0] plot_lin, blit_lin, next_lin;
	logic [5:0]       blit_page;
	logic [7:0]       col_next;
	logic [4:0]       page_next;
	logic [LIN_W-1:0] addr_b;
	logic             a_ok, b_ok;
	logic [15:0]      shifted;
	logic [7:0]       lowmask, plot_bit, wdata_a, wdata_b;

	always_comb begin
		case (mode)
			MODE_PLOT: in_op = ({1'b0, column} < 9'(PAGE_COLUMNS)) ? OP_PLOT : OP_NONE;
			MODE_BBYTE: in_op = blit_active_q ? OP_BLIT : OP_NONE;
			MODE_CLEAR: in_op = OP_CLEAR;
			MODE_READ:  in_op = OP_READ;
			default:    in_op = OP_NONE;
		endcase
	end

	assign plot_lin  = LIN_W'(row[7:3]) * LIN_W'(PAGE_COLUMNS) + LIN_W'(column);
	assign blit_page = 6'(orow_q[7:3]) + 6'(page_q);
	assign blit_lin  = LIN_W'(blit_page) * LIN_W'(PAGE_COLUMNS)
	                 + LIN_W'(ocol_q) + LIN_W'(col_q);

	always_comb begin
		case (in_op)
			OP_PLOT: next_lin = plot_lin;
			OP_BLIT: next_lin = blit_lin;
			default: next_lin = LIN_W'(address);
		endcase
	end

	assign col_next  = col_q + 8'd1;
	assign page_next = page_q + 5'd1;

	// blit bookkeeping and command latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ocol_q        <= '0;
			orow_q        <= '0;
			cols_q        <= '0;
			pages_q       <= '0;
			inv_q         <= 1'b0;
			col_q         <= '0;
			page_q        <= '0;
			blit_active_q <= 1'b0;
			op_q          <= OP_NONE;
			clr_q         <= '0;
		end else begin
			if (cmd.accept) begin
				op_q <= in_op;
				if (mode == MODE_BSTART) begin
					ocol_q        <= column;
					orow_q        <= row;
					cols_q        <= bwidth;
					pages_q       <= bheight[7:3];
					inv_q         <= (color != COLOR_CLEAR);
					col_q         <= '0;
					page_q        <= '0;
					blit_active_q <= (bwidth != 8'd0) && (bheight[7:3] != 5'd0);
				end else if (in_op == OP_BLIT) begin
					// advance columns first, then pages
					if (col_next >= cols_q) begin
						col_q <= '0;
						if (page_next >= pages_q) begin
							page_q        <= '0;
							blit_active_q <= 1'b0;
						end else begin
							page_q <= page_next;
						end
					end else begin
						col_q <= col_next;
					end
				end
			end
			if (cmd.clr_step) clr_q <= stat.clr_last ? '0 : clr_q + MAW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q  <= next_lin;
			shift_q <= (in_op == OP_BLIT) ? orow_q[2:0] : row[2:0];
			data_q  <= pixels ^ {8{inv_q}};
			color_q <= color;
		end
		if (cmd.accept) rd_q <= '0;
		else if (cmd.wr_a) rd_q <= (op_q == OP_READ && a_ok) ? mem_rdata_q : 8'd0;
		if (cmd.load_out) out_q <= M_TDATA_W'({blit_active_q, rd_q});
	end

	assign addr_b   = addr_q + LIN_W'(PAGE_COLUMNS);
	assign a_ok     = addr_q < LIN_W'(STORE_BYTES);
	assign b_ok     = addr_b < LIN_W'(STORE_BYTES);
	assign shifted  = 16'(data_q) << shift_q;
	assign lowmask  = (8'd1 << shift_q) - 8'd1;
	assign plot_bit = 8'd1 << shift_q;

	always_comb begin
		if (op_q == OP_PLOT) begin
			case (color_q)
				COLOR_SET:   wdata_a = mem_rdata_q | plot_bit;
				COLOR_CLEAR: wdata_a = mem_rdata_q & ~plot_bit;
				default:     wdata_a = mem_rdata_q ^ plot_bit;
			endcase
		end else begin
			wdata_a = (mem_rdata_q & lowmask) | (shifted[7:0] & ~lowmask);
		end
	end

	assign wdata_b = (mem_rdata_q & ~lowmask) | (shifted[15:8] & lowmask);

	assign mem_we = cmd.clr_step
	             || (cmd.wr_a && a_ok && (op_q == OP_PLOT || op_q == OP_BLIT))
	             || (cmd.wr_b && b_ok);
	assign mem_re = cmd.rd_a || cmd.rd_b;

	always_comb begin
		if (cmd.clr_step) begin
			mem_idx   = clr_q;
			mem_wdata = 8'd0;
		end else if (cmd.rd_b || cmd.wr_b) begin
			mem_idx   = addr_b[MAW-1:0];
			mem_wdata = wdata_b;
		end else begin
			mem_idx   = addr_q[MAW-1:0];
			mem_wdata = wdata_a;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_idx] <= mem_wdata;
		if (mem_re) mem_rdata_q <= mem[mem_idx];
	end

	assign stat.in_op    = in_op;
	assign stat.need_b   = (op_q == OP_BLIT) && (shift_q != 3'd0);
	assign stat.clr_last = (clr_q == MAW'(STORE_BYTES - 1));
	assign m_tdata       = out_q;

`ifndef NO_ASSERTIONS
	a_active_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		blit_active_q |-> (cols_q != 8'd0) && (pages_q != 5'd0))
		else $error("blit active with an empty extent");

	a_counts_in_extent: assert property (@(posedge clk) disable iff (!arst_n)
		blit_active_q |-> (col_q < cols_q) && (page_q < pages_q))
		else $error("blit counters ran past the extent");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !cmd.clr_step) |-> (cmd.wr_a ? a_ok : b_ok))
		else $error("store write outside the store");
`endif

endmodule

### hdl/page_framebuffer_draw_engine_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Signals                     Content
// s_        in   tvalid tready tdata tuser   draw / blit / clear / read command
// m_        out  tvalid tready tdata         read_data and blit_busy, one per command
//
// A blit byte updates one page byte when its origin row is page-aligned, and two
// page bytes otherwise.
// A no-op is a plot with its column past the page, a blit byte with no blit
// running, or a spare mode.
// The frame store is single-port (one read or one write per cycle).
// After reset a clearing pass over all STORE_BYTES bytes runs with s_tready low.
// One command is in flight at a time; a held result does not block acceptance,
// only the next result load.

module page_framebuffer_draw_engine_core #(
	parameter int STORE_BYTES  = 1024,
	parameter int PAGE_COLUMNS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// column[7:0] row[15:8] color[17:16] blit_width[25:18] blit_height[33:26]
	// pixels[41:34] address[51:42], zero fill above
	input  logic [pfde_pkg::S_TDATA_W-1:0]   s_tdata,
	// mode[2:0]
	input  logic [pfde_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_data[7:0] blit_busy[8], zero fill above
	output logic [pfde_pkg::M_TDATA_W-1:0]   m_tdata
);
	import pfde_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	pfde_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pfde_dpath #(
		.STORE_BYTES  (STORE_BYTES),
		.PAGE_COLUMNS (PAGE_COLUMNS)
	) u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.stat    (stat),
		.m_tdata (m_tdata)
	);

endmodule
